@@ hw/rtl/cfpc_pkg.sv @@
package cfpc_pkg;

    // motor lanes: rear right, rear left, front right, front left
    localparam int NumMotors = 4;

    localparam int TempW     = 8;
    localparam int DutyW     = 7;
    localparam int TimeW     = 32;
    localparam int IntervalW = 16;
    localparam int CfgIndexW = 1;
    localparam int CfgDataW  = 16;

    localparam int TempOffset         = 40;
    localparam int CoolLimit          = 40;
    localparam int WarnLimit          = 90;
    localparam int FullDuty           = 100;
    localparam int FaultTempReset     = 110;
    localparam int CheckIntervalReset = 1000;

    // register indexes on the config channel
    typedef enum logic [CfgIndexW-1:0] {
        CFG_FAULT_TEMP     = 1'b0,
        CFG_CHECK_INTERVAL = 1'b1
    } cfg_index_t;

    // per-motor result handed from a lane to the merge stage
    typedef struct packed {
        logic [TempW-1:0] temp;       // stored temperature after this word
        logic             force_full; // missing or hot motor
        logic             fault;      // sticky fault bit after this word
        logic             warn;       // sticky warn bit after this word
    } lane_status_t;

    typedef struct packed {
        logic [DutyW-1:0] fan;
        logic [DutyW-1:0] pump;
    } merge_out_t;

endpackage

@@ hw/rtl/cfpc_sample_if.sv @@
interface cfpc_sample_if;
    logic                           valid;
    logic                           ready;
    logic [cfpc_pkg::TempW-1:0]     temp_rear_right;
    logic [cfpc_pkg::TempW-1:0]     temp_rear_left;
    logic [cfpc_pkg::TempW-1:0]     temp_front_right;
    logic [cfpc_pkg::TempW-1:0]     temp_front_left;
    logic [cfpc_pkg::NumMotors-1:0] received_mask;
    logic [cfpc_pkg::TempW-1:0]     left_inlet;
    logic [cfpc_pkg::TempW-1:0]     left_outlet;
    logic [cfpc_pkg::TempW-1:0]     right_inlet;
    logic [cfpc_pkg::TempW-1:0]     right_outlet;
    logic [cfpc_pkg::TimeW-1:0]     now_ms;

    modport source (
        output valid, temp_rear_right, temp_rear_left, temp_front_right,
               temp_front_left, received_mask, left_inlet, left_outlet,
               right_inlet, right_outlet, now_ms,
        input  ready
    );

    modport sink (
        input  valid, temp_rear_right, temp_rear_left, temp_front_right,
               temp_front_left, received_mask, left_inlet, left_outlet,
               right_inlet, right_outlet, now_ms,
        output ready
    );
endinterface

@@ hw/rtl/cfpc_result_if.sv @@
interface cfpc_result_if;
    logic                           valid;
    logic                           ready;
    logic [cfpc_pkg::DutyW-1:0]     fan_duty;
    logic [cfpc_pkg::DutyW-1:0]     pump_duty;
    logic [cfpc_pkg::NumMotors-1:0] fault_bits;
    logic [cfpc_pkg::NumMotors-1:0] warn_bits;

    modport source (
        output valid, fan_duty, pump_duty, fault_bits, warn_bits,
        input  ready
    );

    modport sink (
        input  valid, fan_duty, pump_duty, fault_bits, warn_bits,
        output ready
    );
endinterface

@@ hw/rtl/cfpc_cfg_if.sv @@
interface cfpc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cfpc_pkg::CfgIndexW-1:0] index;
    logic [cfpc_pkg::CfgDataW-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hw/rtl/cfpc_lane.sv @@
// One motor: stored temperature, limit checks, sticky fault/warn bits.
module cfpc_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       fresh,
    input  logic [cfpc_pkg::TempW-1:0] temp_in,
    input  logic [cfpc_pkg::TempW-1:0] fault_temp,
    output cfpc_pkg::lane_status_t     status
);
    localparam logic [cfpc_pkg::TempW:0] Offset9 = (cfpc_pkg::TempW+1)'(cfpc_pkg::TempOffset);
    localparam logic [cfpc_pkg::TempW:0] WarnRaw =
        (cfpc_pkg::TempW+1)'(cfpc_pkg::WarnLimit + cfpc_pkg::TempOffset);

    logic [cfpc_pkg::TempW-1:0] temp_reg;
    logic                       fault_reg;
    logic                       warn_reg;
    logic                       fault_hit;
    logic                       warn_hit;

    // 9-bit compare so a limit above 215 simply never trips
    assign fault_hit = fresh && ({1'b0, temp_in} > ({1'b0, fault_temp} + Offset9));
    assign warn_hit  = fresh && ({1'b0, temp_in} > WarnRaw);

    always_comb
    begin
        status.temp       = fresh ? temp_in : temp_reg;
        status.force_full = !fresh || fault_hit || warn_hit;
        status.fault      = fault_reg || fault_hit;
        status.warn       = warn_reg || warn_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg  <= '0;
            fault_reg <= 1'b0;
            warn_reg  <= 1'b0;
        end
        else if (accept)
        begin
            temp_reg  <= status.temp;
            fault_reg <= status.fault;
            warn_reg  <= status.warn;
        end
    end
endmodule

@@ hw/rtl/cfpc_merge.sv @@
// Merge: hottest motor, linear duty, adjust term, fan/pump levels.
module cfpc_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  cfpc_pkg::lane_status_t         lanes [cfpc_pkg::NumMotors],
    input  logic [cfpc_pkg::TempW-1:0]     left_inlet,
    input  logic [cfpc_pkg::TempW-1:0]     left_outlet,
    input  logic [cfpc_pkg::TempW-1:0]     right_inlet,
    input  logic [cfpc_pkg::TempW-1:0]     right_outlet,
    input  logic [cfpc_pkg::TimeW-1:0]     now_ms,
    input  logic [cfpc_pkg::IntervalW-1:0] check_interval_ms,
    output cfpc_pkg::merge_out_t           levels
);
    localparam int TW = cfpc_pkg::TempW;
    localparam int DW = cfpc_pkg::DutyW;
    localparam int XW = cfpc_pkg::TimeW;
    localparam int DutySlope =
        cfpc_pkg::FullDuty / (cfpc_pkg::WarnLimit - cfpc_pkg::CoolLimit);
    localparam logic [TW-1:0] RawOffset = TW'(cfpc_pkg::TempOffset);
    localparam logic [TW-1:0] RawCool   = TW'(cfpc_pkg::CoolLimit + cfpc_pkg::TempOffset);
    localparam logic [TW-1:0] RawWarn   = TW'(cfpc_pkg::WarnLimit + cfpc_pkg::TempOffset);
    localparam logic [TW-1:0] CoolDeg   = TW'(cfpc_pkg::CoolLimit);
    localparam logic [DW-1:0] Full      = DW'(cfpc_pkg::FullDuty);

    logic [DW-1:0] fan_reg;
    logic [DW-1:0] pump_reg;
    logic [TW-1:0] adjust_reg;
    logic [XW-1:0] next_check_reg;
    logic [XW-1:0] last_rise_reg;
    logic [XW-1:0] last_margin_reg;

    logic [TW-1:0] hot_a;
    logic [TW-1:0] hot_b;
    logic [TW-1:0] hottest;
    logic [TW-1:0] deg;
    logic          force_full;
    logic          in_linear;
    logic          is_cold;
    logic          do_check;
    logic          heated;
    logic [TW-1:0] min_in;
    logic [TW-1:0] max_out;
    logic [XW-1:0] rise;
    logic [XW-1:0] margin;
    logic [TW-1:0] adjust_mid;
    logic [TW-1:0] adjust_next;
    logic [DW-1:0] duty_lin;
    logic [DW+1:0] duty_sum;
    logic [DW-1:0] duty_final;
    logic [DW-1:0] fan_next;
    logic [DW-1:0] pump_next;

    function automatic logic [TW-1:0] adj_step(input logic [TW-1:0] a, input logic up);
        logic [TW-1:0] r;
        r = a;
        if (up && a != '1)
            r = a + 1'b1;
        else if (!up && a != '0)
            r = a - 1'b1;
        return r;
    endfunction

    // max tree over the four lanes
    assign hot_a   = (lanes[0].temp > lanes[1].temp) ? lanes[0].temp : lanes[1].temp;
    assign hot_b   = (lanes[2].temp > lanes[3].temp) ? lanes[2].temp : lanes[3].temp;
    assign hottest = (hot_a > hot_b) ? hot_a : hot_b;
    assign deg     = hottest - RawOffset;

    assign force_full = lanes[0].force_full || lanes[1].force_full ||
                        lanes[2].force_full || lanes[3].force_full;

    // below the offset the wrapped value is huge: neither range applies
    assign in_linear = (hottest > RawCool) && (hottest < RawWarn);
    assign is_cold   = (hottest >= RawOffset) && (hottest < RawCool);
    assign do_check  = in_linear && (next_check_reg < now_ms);

    assign min_in  = (left_inlet < right_inlet) ? left_inlet : right_inlet;
    assign max_out = (left_outlet > right_outlet) ? left_outlet : right_outlet;
    assign heated  = min_in < max_out;
    assign rise    = XW'(max_out) - XW'(min_in);
    assign margin  = XW'(deg) - XW'(max_out);

    assign adjust_mid  = adj_step(adjust_reg, rise > last_rise_reg);
    assign adjust_next = (do_check && heated) ?
                         adj_step(adjust_mid, margin > last_margin_reg) : adjust_reg;

    assign duty_lin   = DW'((deg - CoolDeg) * TW'(DutySlope));
    assign duty_sum   = (DW+2)'(duty_lin) + (DW+2)'(adjust_next);
    assign duty_final = (duty_sum < (DW+2)'(cfpc_pkg::FullDuty)) ? duty_sum[DW-1:0] : Full;

    always_comb
    begin
        fan_next  = force_full ? Full : fan_reg;
        pump_next = pump_reg;
        if (in_linear)
            fan_next = duty_final;
        if (is_cold)
        begin
            fan_next  = '0;
            pump_next = '0;
        end
        if (fan_next != '0)
            pump_next = Full;
    end

    assign levels.fan  = fan_next;
    assign levels.pump = pump_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_reg         <= '0;
            pump_reg        <= '0;
            adjust_reg      <= '0;
            next_check_reg  <= '0;
            last_rise_reg   <= '0;
            last_margin_reg <= '0;
        end
        else if (accept)
        begin
            fan_reg    <= fan_next;
            pump_reg   <= pump_next;
            adjust_reg <= adjust_next;
            if (do_check)
            begin
                last_rise_reg   <= rise;
                last_margin_reg <= margin;
                next_check_reg  <= now_ms + XW'(check_interval_ms);
            end
        end
    end

    // adjust term moves by at most two per word
    a_adjust_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |->
        ((adjust_reg >= $past(adjust_reg) ? adjust_reg - $past(adjust_reg)
                                          : $past(adjust_reg) - adjust_reg) <= TW'(2)))
        else $error("adjust term jumped");

    // adjust term only changes on a check step
    a_adjust_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !do_check |=> adjust_reg == $past(adjust_reg))
        else $error("adjust term changed outside a check");

    // cold system shuts the fan and the pump off
    a_cold_off: assert property (@(posedge clk) disable iff (!rst_n)
        is_cold |-> levels.pump == '0 && levels.fan == '0)
        else $error("pump running while cold");
endmodule

@@ hw/rtl/coolant_fan_pump_controller.sv @@
// An accepted sample word's result is registered and shows in the next cycle.
// Throughput: one word per cycle while results are being read; the controller state
// (motor temps, levels, adjust term, check timer) updates in the accept cycle itself.
// A waiting result word blocks intake until read; a read frees the slot in the same cycle.
// Reset (rst_n, async, active low): lane and merge state zero, fault_temp 110,
// check_interval_ms 1000, no result pending.
module coolant_fan_pump_controller (
    input  logic         clk,
    input  logic         rst_n,
    cfpc_sample_if.sink  sample,
    cfpc_result_if.source result,
    cfpc_cfg_if.sink     cfg
);
    localparam int NM = cfpc_pkg::NumMotors;

    // configuration registers
    logic [cfpc_pkg::TempW-1:0]     fault_temp_reg;
    logic [cfpc_pkg::IntervalW-1:0] interval_reg;

    // result register
    logic                           out_valid_reg;
    logic [cfpc_pkg::DutyW-1:0]     fan_reg;
    logic [cfpc_pkg::DutyW-1:0]     pump_reg;
    logic [NM-1:0]                  fault_reg;
    logic [NM-1:0]                  warn_reg;

    logic                           accept;
    logic [cfpc_pkg::TempW-1:0]     motor_temp [NM];
    cfpc_pkg::lane_status_t         lanes [NM];
    cfpc_pkg::merge_out_t           levels;
    logic [NM-1:0]                  fault_next;
    logic [NM-1:0]                  warn_next;

    // take a new word whenever the result slot is empty or being drained
    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_temp_reg <= cfpc_pkg::TempW'(cfpc_pkg::FaultTempReset);
            interval_reg   <= cfpc_pkg::IntervalW'(cfpc_pkg::CheckIntervalReset);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cfpc_pkg::CFG_FAULT_TEMP:     fault_temp_reg <= cfg.data[cfpc_pkg::TempW-1:0];
                cfpc_pkg::CFG_CHECK_INTERVAL: interval_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // lane order matches received_mask bit order
    assign motor_temp[0] = sample.temp_rear_right;
    assign motor_temp[1] = sample.temp_rear_left;
    assign motor_temp[2] = sample.temp_front_right;
    assign motor_temp[3] = sample.temp_front_left;

    for (genvar i = 0; i < NM; i++)
    begin : g_lane
        cfpc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (accept),
            .fresh      (sample.received_mask[i]),
            .temp_in    (motor_temp[i]),
            .fault_temp (fault_temp_reg),
            .status     (lanes[i])
        );
        assign fault_next[i] = lanes[i].fault;
        assign warn_next[i]  = lanes[i].warn;
    end

    cfpc_merge u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .lanes             (lanes),
        .left_inlet        (sample.left_inlet),
        .left_outlet       (sample.left_outlet),
        .right_inlet       (sample.right_inlet),
        .right_outlet      (sample.right_outlet),
        .now_ms            (sample.now_ms),
        .check_interval_ms (interval_reg),
        .levels            (levels)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fan_reg   <= levels.fan;
            pump_reg  <= levels.pump;
            fault_reg <= fault_next;
            warn_reg  <= warn_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.fan_duty   = fan_reg;
    assign result.pump_duty  = pump_reg;
    assign result.fault_bits = fault_reg;
    assign result.warn_bits  = warn_reg;

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted word produced no result");

    a_fan_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.fan_duty <= cfpc_pkg::DutyW'(cfpc_pkg::FullDuty))
        else $error("fan duty above full");

    a_fan_pump: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.fan_duty != '0 |->
        result.pump_duty == cfpc_pkg::DutyW'(cfpc_pkg::FullDuty))
        else $error("fan running without pump");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && $past(accept) |=>
        ((fault_reg & $past(fault_reg)) == $past(fault_reg)) &&
        ((warn_reg & $past(warn_reg)) == $past(warn_reg)))
        else $error("sticky bit cleared");
endmodule

@@ tb/tb_coolant_fan_pump_controller.sv @@
module tb_coolant_fan_pump_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import cfpc_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int PhaseWords   = 320;   // random words per config setting
    localparam int RampLen      = 40;    // words in one rising-coolant ramp
    localparam int LongHoldAt   = 600;   // accepted words before the long sink stall
    localparam int LongHoldLen  = 300;

    // one sample word as the sender sees it
    typedef struct packed {
        logic [TempW-1:0]     temp_rear_right;
        logic [TempW-1:0]     temp_rear_left;
        logic [TempW-1:0]     temp_front_right;
        logic [TempW-1:0]     temp_front_left;
        logic [NumMotors-1:0] received_mask;
        logic [TempW-1:0]     left_inlet;
        logic [TempW-1:0]     left_outlet;
        logic [TempW-1:0]     right_inlet;
        logic [TempW-1:0]     right_outlet;
        logic [TimeW-1:0]     now_ms;
    } sensor_word_t;

    // one result word: fan/pump command plus sticky flags
    typedef struct packed {
        logic [DutyW-1:0]     fan;
        logic [DutyW-1:0]     pump;
        logic [NumMotors-1:0] fault;
        logic [NumMotors-1:0] warn;
    } cooling_cmd_t;

    logic clk;
    logic rst_n;

    cfpc_sample_if sample_bus ();
    cfpc_result_if result_bus ();
    cfpc_cfg_if    cfg_bus ();

    coolant_fan_pump_controller DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // ------------------------------------------------------------------
    // Controller shadow state, starts at its reset values
    // ------------------------------------------------------------------
    logic [TempW-1:0]     fault_limit    = TempW'(FaultTempReset);
    logic [IntervalW-1:0] check_interval = IntervalW'(CheckIntervalReset);
    logic [TempW-1:0]     lane_temp [NumMotors] = '{default: '0};
    logic [DutyW-1:0]     fan_now        = '0;
    logic [DutyW-1:0]     pump_now       = '0;
    logic [7:0]           adjust         = '0;
    logic [TimeW-1:0]     next_check_ms  = '0;
    logic [31:0]          prior_rise     = '0;
    logic [31:0]          prior_margin   = '0;
    logic [NumMotors-1:0] fault_seen     = '0;
    logic [NumMotors-1:0] warn_seen      = '0;

    sensor_word_t sensor_pending [$];   // words waiting for the driver
    cooling_cmd_t cmd_expected [$];     // commands predicted, not yet seen
    sensor_word_t inflight;             // word currently on the sample bus

    logic [TimeW-1:0] sim_now = '0;     // timeline used to build well-formed words
    bit  calm           = 1'b0;         // no idling on either side once set
    bit  long_hold_done = 1'b0;
    int  words_in       = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  tx_gap         = 0;
    int  rx_gap         = 0;
    int  hold_left      = 0;

    // adjust term saturates at both ends
    task automatic nudge_adjust(input bit up);
        if (up)
        begin
            if (adjust != 8'hFF)
                adjust = adjust + 8'd1;
        end
        else if (adjust != 8'h00)
        begin
            adjust = adjust - 8'd1;
        end
    endtask

    // Advance the shadow controller by one accepted sample word.
    task automatic step_controller(input sensor_word_t w, output cooling_cmd_t c);
        logic [TempW-1:0] fresh [NumMotors];
        logic [31:0] hottest, m, duty, min_in, max_out, rise, margin;
        fresh[0] = w.temp_rear_right;
        fresh[1] = w.temp_rear_left;
        fresh[2] = w.temp_front_right;
        fresh[3] = w.temp_front_left;
        // forcing per lane: missing or hot motor runs the fan flat out
        for (int i = 0; i < NumMotors; i++)
        begin
            if (w.received_mask[i])
            begin
                lane_temp[i] = fresh[i];
                if (32'(fresh[i]) > 32'(fault_limit) + TempOffset)
                begin
                    fan_now = DutyW'(FullDuty);
                    fault_seen[i] = 1'b1;
                end
                if (32'(fresh[i]) > WarnLimit + TempOffset)
                begin
                    fan_now = DutyW'(FullDuty);
                    warn_seen[i] = 1'b1;
                end
            end
            else
            begin
                fan_now = DutyW'(FullDuty);
            end
        end
        hottest = '0;
        for (int i = 0; i < NumMotors; i++)
            if (32'(lane_temp[i]) > hottest)
                hottest = 32'(lane_temp[i]);
        // wraps to a huge value when the hottest lane is under the offset
        m = hottest - TempOffset;
        if (m < WarnLimit && m > CoolLimit)
        begin
            duty = (m - CoolLimit) * FullDuty / (WarnLimit - CoolLimit);
            if (next_check_ms < w.now_ms)
            begin
                min_in  = (w.left_inlet < w.right_inlet) ? 32'(w.left_inlet)
                                                         : 32'(w.right_inlet);
                max_out = (w.left_outlet > w.right_outlet) ? 32'(w.left_outlet)
                                                           : 32'(w.right_outlet);
                rise   = max_out - min_in;
                margin = m - max_out;
                // adjust only moves when the coolant is actually heated
                if (min_in < max_out)
                begin
                    nudge_adjust(rise > prior_rise);
                    nudge_adjust(margin > prior_margin);
                end
                prior_rise    = rise;
                prior_margin  = margin;
                next_check_ms = w.now_ms + 32'(check_interval);
            end
            if (duty + adjust < FullDuty)
                duty = duty + adjust;
            else
                duty = FullDuty;
            fan_now = duty[DutyW-1:0];
        end
        if (m < CoolLimit)
        begin
            fan_now  = '0;
            pump_now = '0;
        end
        if (fan_now != '0)
            pump_now = DutyW'(FullDuty);
        c.fan   = fan_now;
        c.pump  = pump_now;
        c.fault = fault_seen;
        c.warn  = warn_seen;
    endtask

    function automatic sensor_word_t mk(input logic [7:0] rr, rl, fr, fl,
                                        input logic [3:0] mask,
                                        input logic [7:0] li, lo, ri, ro,
                                        input logic [31:0] now);
        sensor_word_t w;
        w.temp_rear_right  = rr;
        w.temp_rear_left   = rl;
        w.temp_front_right = fr;
        w.temp_front_left  = fl;
        w.received_mask    = mask;
        w.left_inlet       = li;
        w.left_outlet      = lo;
        w.right_inlet      = ri;
        w.right_outlet     = ro;
        w.now_ms           = now;
        return w;
    endfunction

    // Typical operating word: motors near the linear band, coolant mostly
    // heated, time moving forward by up to two check intervals plus one ms.
    function automatic sensor_word_t heated_word();
        sensor_word_t w;
        w.temp_rear_right  = 8'($urandom_range(60, 135));
        w.temp_rear_left   = 8'($urandom_range(60, 135));
        w.temp_front_right = 8'($urandom_range(60, 135));
        w.temp_front_left  = 8'($urandom_range(60, 135));
        w.received_mask    = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'hF;
        w.left_inlet       = 8'($urandom_range(10, 70));
        w.right_inlet      = 8'($urandom_range(10, 70));
        if ($urandom_range(0, 6) == 0)
        begin
            w.left_outlet  = 8'($urandom_range(0, w.left_inlet));
            w.right_outlet = 8'($urandom_range(0, w.right_inlet));
        end
        else
        begin
            w.left_outlet  = w.left_inlet + 8'($urandom_range(0, 40));
            w.right_outlet = w.right_inlet + 8'($urandom_range(0, 40));
        end
        sim_now  = sim_now + $urandom_range(0, 2 * check_interval + 1);
        w.now_ms = sim_now;
        return w;
    endfunction

    // Ramp: rise and margin both grow each check, drives the adjust term up
    // toward saturation. Max outlet fixed at 40 keeps the margin from wrapping.
    function automatic sensor_word_t ramp_word(input int k);
        sensor_word_t w;
        logic [7:0] t [NumMotors];
        int hot;
        hot = $urandom_range(0, NumMotors - 1);
        for (int i = 0; i < NumMotors; i++)
            t[i] = (i == hot) ? 8'(81 + k) : 8'($urandom_range(0, 81 + k));
        w = mk(t[0], t[1], t[2], t[3], 4'hF,
               8'(39 - k), 8'd40, 8'($urandom_range(39 - k, 255)), 8'($urandom_range(0, 40)),
               '0);
        sim_now  = sim_now + 32'(check_interval) + $urandom_range(1, 4);
        w.now_ms = sim_now;
        return w;
    endfunction

    // Anything goes; occasionally a far time jump, kept below the top
    // quarter so the timeline never wraps under a pending check.
    function automatic sensor_word_t noise_word();
        sensor_word_t w;
        logic [31:0] t;
        w = mk(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), '0);
        if ($urandom_range(0, 3) == 0)
        begin
            t = $urandom_range(0, 32'hBFFF_FFFF);
            if (t > sim_now)
                sim_now = t;
            w.now_ms = t;
        end
        else
        begin
            sim_now  = sim_now + $urandom_range(0, 2 * check_interval + 1);
            w.now_ms = sim_now;
        end
        return w;
    endfunction

    task automatic queue_random_phase(input int target);
        int n;
        int pick;
        int len;
        n = 0;
        while (n < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                for (int k = 0; k < RampLen; k++)
                    sensor_pending.push_back(ramp_word(k));
                n += RampLen;
            end
            else if (pick < 80)
            begin
                len = $urandom_range(5, 20);
                for (int k = 0; k < len; k++)
                    sensor_pending.push_back(heated_word());
                n += len;
            end
            else
            begin
                sensor_pending.push_back(noise_word());
                n++;
            end
        end
    endtask

    // Config write: only called while nothing is in flight.
    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_FAULT_TEMP:     fault_limit    = val[TempW-1:0];
            CFG_CHECK_INTERVAL: check_interval = val[IntervalW-1:0];
            default: ;
        endcase
    endtask

    // Sender holds off until every predicted command has come back.
    // Sampled on the falling edge so all edge updates have settled.
    task automatic drain();
        while (sensor_pending.size() != 0 || sample_bus.valid || cmd_expected.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);   // slack after the last result word
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sample driver: pops the pending queue, predicts on each accepted word
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sample_drive
        cooling_cmd_t c;
        if (!rst_n)
        begin
            sample_bus.valid            <= 1'b0;
            sample_bus.temp_rear_right  <= '0;
            sample_bus.temp_rear_left   <= '0;
            sample_bus.temp_front_right <= '0;
            sample_bus.temp_front_left  <= '0;
            sample_bus.received_mask    <= '0;
            sample_bus.left_inlet       <= '0;
            sample_bus.left_outlet      <= '0;
            sample_bus.right_inlet      <= '0;
            sample_bus.right_outlet     <= '0;
            sample_bus.now_ms           <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
            begin
                step_controller(inflight, c);
                cmd_expected.push_back(c);
                words_in++;
            end
            // bus slot free: idle burst, next word, or nothing to send
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    sample_bus.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    tx_gap = $urandom_range(0, 17);
                    sample_bus.valid <= 1'b0;
                end
                else if (sensor_pending.size() != 0)
                begin
                    inflight = sensor_pending.pop_front();
                    sample_bus.temp_rear_right  <= inflight.temp_rear_right;
                    sample_bus.temp_rear_left   <= inflight.temp_rear_left;
                    sample_bus.temp_front_right <= inflight.temp_front_right;
                    sample_bus.temp_front_left  <= inflight.temp_front_left;
                    sample_bus.received_mask    <= inflight.received_mask;
                    sample_bus.left_inlet       <= inflight.left_inlet;
                    sample_bus.left_outlet      <= inflight.left_outlet;
                    sample_bus.right_inlet      <= inflight.right_inlet;
                    sample_bus.right_outlet     <= inflight.right_outlet;
                    sample_bus.now_ms           <= inflight.now_ms;
                    sample_bus.valid            <= 1'b1;
                end
                else
                begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink ready: random stall bursts plus one long hold-off that
    // lets the result register fill and back up into the sample input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            rx_gap    = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else if (!long_hold_done && words_in >= LongHoldAt)
        begin
            long_hold_done = 1'b1;
            hold_left = LongHoldLen - 1;
            result_bus.ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            result_bus.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            rx_gap = $urandom_range(0, 17);
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        cooling_cmd_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (cmd_expected.size() == 0)
            begin
                flag_mismatch($sformatf("result word with nothing expected: fan %0d pump %0d",
                                        result_bus.fan_duty, result_bus.pump_duty));
            end
            else
            begin
                want = cmd_expected.pop_front();
                if (result_bus.fan_duty !== want.fan || result_bus.pump_duty !== want.pump ||
                    result_bus.fault_bits !== want.fault ||
                    result_bus.warn_bits !== want.warn)
                    flag_mismatch($sformatf(
                        "fan %0d/%0d pump %0d/%0d fault %b/%b warn %b/%b (exp/act)",
                        want.fan, result_bus.fan_duty, want.pump, result_bus.pump_duty,
                        want.fault, result_bus.fault_bits, want.warn, result_bus.warn_bits));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // config bus idle from time zero
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_FAULT_TEMP;
        cfg_bus.data  = '0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at reset config (fault above 150 raw, 1000 ms checks)
        // missing motors force full fan, pump follows
        sensor_pending.push_back(mk(8'd0, 8'd0, 8'd0, 8'd0, 4'h0,
                                    8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        // all fresh but under the offset: no band applies, fan holds at 100
        sensor_pending.push_back(mk(8'd0, 8'd0, 8'd0, 8'd0, 4'hF,
                                    8'd0, 8'd0, 8'd0, 8'd0, 32'd0));
        // 39 degrees: cold shutdown
        sensor_pending.push_back(mk(8'd79, 8'd79, 8'd79, 8'd79, 4'hF,
                                    8'd0, 8'd0, 8'd0, 8'd0, 32'd1));
        // exactly 40 degrees: neither band, stays off
        sensor_pending.push_back(mk(8'd80, 8'd80, 8'd80, 8'd80, 4'hF,
                                    8'd0, 8'd0, 8'd0, 8'd0, 32'd2));
        // bottom of linear band, first check passes (0 < 5)
        sensor_pending.push_back(mk(8'd81, 8'd81, 8'd81, 8'd81, 4'hF,
                                    8'd20, 8'd30, 8'd20, 8'd30, 32'd5));
        // same time as next check: no check
        sensor_pending.push_back(mk(8'd81, 8'd81, 8'd81, 8'd81, 4'hF,
                                    8'd20, 8'd30, 8'd20, 8'd30, 32'd1005));
        // coolant not heated: adjust untouched, differences still stored
        sensor_pending.push_back(mk(8'd81, 8'd81, 8'd81, 8'd81, 4'hF,
                                    8'd200, 8'd10, 8'd200, 8'd10, 32'd1006));
        // top of linear band
        sensor_pending.push_back(mk(8'd129, 8'd129, 8'd129, 8'd129, 4'hF,
                                    8'd30, 8'd90, 8'd35, 8'd60, 32'd3000));
        // 90 degrees: out of band, not yet a warning
        sensor_pending.push_back(mk(8'd130, 8'd100, 8'd100, 8'd100, 4'hF,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd3100));
        // warning edge on rear left
        sensor_pending.push_back(mk(8'd130, 8'd131, 8'd100, 8'd100, 4'hF,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd3200));
        // fault edge: at the limit is no fault
        sensor_pending.push_back(mk(8'd130, 8'd131, 8'd150, 8'd100, 4'hF,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd3300));
        sensor_pending.push_back(mk(8'd130, 8'd131, 8'd150, 8'd151, 4'hF,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd3400));
        // stale data ignored, stored values kept
        sensor_pending.push_back(mk(8'd255, 8'd255, 8'd255, 8'd255, 4'h0,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd3500));
        sensor_pending.push_back(mk(8'd100, 8'd100, 8'd100, 8'd100, 4'hF,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd5000));
        // partial mask: linear duty overrides the forcing to 100
        sensor_pending.push_back(mk(8'd100, 8'd255, 8'd100, 8'd255, 4'b0101,
                                    8'd30, 8'd60, 8'd30, 8'd60, 32'd5001));
        // check near the top of time: next check wraps around
        sensor_pending.push_back(mk(8'd100, 8'd100, 8'd100, 8'd100, 4'hF,
                                    8'd30, 8'd70, 8'd30, 8'd70, 32'hFFFF_FFF0));
        sensor_pending.push_back(mk(8'd100, 8'd100, 8'd100, 8'd100, 4'hF,
                                    8'd30, 8'd70, 8'd30, 8'd70, 32'h10));
        // every lane over both limits
        sensor_pending.push_back(mk(8'd255, 8'd255, 8'd255, 8'd255, 4'hF,
                                    8'd0, 8'd255, 8'd0, 8'd255, 32'h20));
        sensor_pending.push_back(mk(8'd0, 8'd0, 8'd0, 8'd0, 4'hF,
                                    8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF));
        sensor_pending.push_back(mk(8'd255, 8'd255, 8'd255, 8'd255, 4'hF,
                                    8'd0, 8'd255, 8'd255, 8'd0, 32'hFFFF_FFFF));
        drain();
        sim_now = 32'h0000_1000;   // past the wrapped check time

        // minimum limits: nearly every lane faults, check once time passes the last check + 1 ms
        write_reg(CFG_FAULT_TEMP, 16'd0);
        write_reg(CFG_CHECK_INTERVAL, 16'd1);
        queue_random_phase(PhaseWords);
        drain();

        // widest legal settings; the long sink stall lands in this phase
        write_reg(CFG_FAULT_TEMP, 16'd215);
        write_reg(CFG_CHECK_INTERVAL, 16'hFFFF);
        queue_random_phase(PhaseWords);
        drain();

        // fault limit out of reach, zero interval
        write_reg(CFG_FAULT_TEMP, 16'd255);
        write_reg(CFG_CHECK_INTERVAL, 16'd0);
        queue_random_phase(PhaseWords);
        drain();

        write_reg(CFG_FAULT_TEMP, 16'($urandom_range(0, 215)));
        write_reg(CFG_CHECK_INTERVAL, 16'($urandom_range(1, 65535)));
        queue_random_phase(PhaseWords);
        drain();

        // back to reset values, full rate on both sides
        calm = 1'b1;
        write_reg(CFG_FAULT_TEMP, 16'(FaultTempReset));
        write_reg(CFG_CHECK_INTERVAL, 16'(CheckIntervalReset));
        queue_random_phase(PhaseWords);
        drain();

        if (mismatch_count == 0 && cmd_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ coolant_fan_pump_controller.f @@
hw/rtl/cfpc_pkg.sv
hw/rtl/cfpc_sample_if.sv
hw/rtl/cfpc_result_if.sv
hw/rtl/cfpc_cfg_if.sv
hw/rtl/cfpc_lane.sv
hw/rtl/cfpc_merge.sv
hw/rtl/coolant_fan_pump_controller.sv
tb/tb_coolant_fan_pump_controller.sv
